>>> rtl/lbcs_pkg.sv
// Shared types and constants for the LED blink-code sequencer.
// Holds the field widths, phase and action codes, register indexes, reset values and state bundle; depends on nothing.
package lbcs_pkg;

    // Field widths
    localparam int unsigned MS_W     = 16;
    localparam int unsigned BLINK_W  = 5;
    localparam int unsigned ROUND_W  = 4;
    localparam int unsigned SRC_W    = 4;
    localparam int unsigned CODE_W   = 5;
    localparam int unsigned HALF_W   = 10;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned ACTION_W = 2;

    // Sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SRC_ON    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SRC_OFF   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SRC_GAP   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CODE_ON   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CODE_OFF  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_ROUND_GAP = 3'd6;

    // Input actions
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_OFF     = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_SOURCE_GAP  = 2'd0;
    localparam logic [1:0] REG_ROUND_GAP   = 2'd1;
    localparam logic [1:0] REG_ROUND_TOTAL = 2'd2;

    // Reset values of the configuration registers
    localparam logic [MS_W-1:0]    SOURCE_GAP_RST  = 16'd500;
    localparam logic [MS_W-1:0]    ROUND_GAP_RST   = 16'd1500;
    localparam logic [ROUND_W-1:0] ROUND_TOTAL_RST = 4'd2;

    // Phase, time left in the phase and blinks left, as one bundle
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [MS_W-1:0]    ms;
        logic [BLINK_W-1:0] blinks;
    } seq_t;

endpackage

>>> rtl/led_blink_code_sequencer.sv
// Top level of the LED blink-code sequencer: sequencer state registers, one-pass
// next-state logic and a registered result word. Depends on lbcs_pkg.
//
// The block takes one word per clock: a one-millisecond tick, a blink request
// or a force-off command (selected by s_axis_tuser), and answers each word with
// one result word carrying the LED state, the busy flag and whether a request
// was taken. Each word is handled in one pass of next-state logic; its
// result appears on the output register in the cycle after acceptance, and a new
// word is accepted every cycle as long as the output register is empty or
// being drained in the same cycle. Zero-length phases (a zero source gap, zero
// counts) are passed over within that same pass. Configuration writes are
// always accepted and take effect on the next word.
module led_blink_code_sequencer
    import lbcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    // Input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] source_count, [8:4] code_count, [18:9] half_period_ms,
    // [19] forever_req, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    // Result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] led_on, [1] busy_res, [2] request_taken, [7:3] zero
    output logic [7:0]  m_axis_tdata
);

    // Configuration registers
    logic [MS_W-1:0]    source_gap_reg;
    logic [MS_W-1:0]    round_gap_reg;
    logic [ROUND_W-1:0] round_total_reg;

    // Sequencer state
    seq_t               seq_reg, seq_next;
    logic [ROUND_W-1:0] rounds_done_reg, rounds_done_next;
    logic [SRC_W-1:0]   held_src_reg, held_src_next;
    logic [CODE_W-1:0]  held_code_reg, held_code_next;
    logic [HALF_W-1:0]  held_half_reg, held_half_next;
    logic               held_forever_reg, held_forever_next;

    // Result register
    logic               out_valid_reg;
    logic [2:0]         out_data_reg, out_data_next;

    // Input field views
    logic [ACTION_W-1:0] in_action;
    logic [SRC_W-1:0]    in_src;
    logic [CODE_W-1:0]   in_code;
    logic [HALF_W-1:0]   in_half;
    logic                in_forever;
    logic                in_accept;
    logic                taken;

    assign in_action  = s_axis_tuser;
    assign in_src     = s_axis_tdata[3:0];
    assign in_code    = s_axis_tdata[8:4];
    assign in_half    = s_axis_tdata[18:9];
    assign in_forever = s_axis_tdata[19];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};

    // Entry after the source gap: code blinks, or straight to the round gap.
    function automatic seq_t after_src_gap(
        input logic [BLINK_W-1:0] blinks_in,
        input logic [CODE_W-1:0]  code,
        input logic [HALF_W-1:0]  half,
        input logic [MS_W-1:0]    rg
    );
        seq_t s;
        s.blinks = blinks_in;
        if (code != '0)
        begin
            s.phase  = PH_CODE_ON;
            s.ms     = {{(MS_W-HALF_W){1'b0}}, half};
            s.blinks = code;
        end
        else
        begin
            s.phase = PH_ROUND_GAP;
            s.ms    = (rg != '0) ? rg : MS_W'(1);
        end
        return s;
    endfunction

    // Entry into the source gap, passed over when its length is zero.
    function automatic seq_t enter_src_gap(
        input logic [BLINK_W-1:0] blinks_in,
        input logic [CODE_W-1:0]  code,
        input logic [HALF_W-1:0]  half,
        input logic [MS_W-1:0]    sg,
        input logic [MS_W-1:0]    rg
    );
        seq_t s;
        if (sg != '0)
        begin
            s.phase  = PH_SRC_GAP;
            s.ms     = sg;
            s.blinks = blinks_in;
        end
        else
        begin
            s = after_src_gap(blinks_in, code, half, rg);
        end
        return s;
    endfunction

    // Start of a round: source blinks, or the source gap when there are none.
    function automatic seq_t begin_round(
        input logic [SRC_W-1:0]  src,
        input logic [CODE_W-1:0] code,
        input logic [HALF_W-1:0] half,
        input logic [MS_W-1:0]   sg,
        input logic [MS_W-1:0]   rg
    );
        seq_t s;
        if (src != '0)
        begin
            s.phase  = PH_SRC_ON;
            s.ms     = {{(MS_W-HALF_W){1'b0}}, half};
            s.blinks = {{(BLINK_W-SRC_W){1'b0}}, src};
        end
        else
        begin
            s = enter_src_gap('0, code, half, sg, rg);
        end
        return s;
    endfunction

    // Next state for one accepted word.
    always_comb
    begin
        logic [ROUND_W-1:0] total;
        logic [BLINK_W-1:0] bl_dec;
        logic [MS_W-1:0]    half_ms;

        seq_next          = seq_reg;
        rounds_done_next  = rounds_done_reg;
        held_src_next     = held_src_reg;
        held_code_next    = held_code_reg;
        held_half_next    = held_half_reg;
        held_forever_next = held_forever_reg;
        taken             = 1'b0;
        total             = (round_total_reg != '0) ? round_total_reg : ROUND_W'(1);
        bl_dec            = seq_reg.blinks - BLINK_W'(1);
        half_ms           = {{(MS_W-HALF_W){1'b0}}, held_half_reg};

        case (in_action)
            ACT_TICK:
            begin
                if (seq_reg.phase != PH_IDLE)
                begin
                    if (seq_reg.ms != '0)
                    begin
                        seq_next.ms = seq_reg.ms - MS_W'(1);
                    end
                    // Phase ends: move on, passing over zero-length phases.
                    if (seq_next.ms == '0)
                    begin
                        case (seq_reg.phase)
                            PH_SRC_ON:
                            begin
                                seq_next.phase = PH_SRC_OFF;
                                seq_next.ms    = half_ms;
                            end
                            PH_SRC_OFF:
                            begin
                                if (bl_dec != '0)
                                begin
                                    seq_next.phase  = PH_SRC_ON;
                                    seq_next.ms     = half_ms;
                                    seq_next.blinks = bl_dec;
                                end
                                else
                                begin
                                    seq_next = enter_src_gap(bl_dec, held_code_reg,
                                        held_half_reg, source_gap_reg, round_gap_reg);
                                end
                            end
                            PH_SRC_GAP:
                            begin
                                seq_next = after_src_gap(seq_reg.blinks, held_code_reg,
                                    held_half_reg, round_gap_reg);
                            end
                            PH_CODE_ON:
                            begin
                                seq_next.phase = PH_CODE_OFF;
                                seq_next.ms    = half_ms;
                            end
                            PH_CODE_OFF:
                            begin
                                seq_next.blinks = bl_dec;
                                if (bl_dec != '0)
                                begin
                                    seq_next.phase = PH_CODE_ON;
                                    seq_next.ms    = half_ms;
                                end
                                else
                                begin
                                    seq_next.phase = PH_ROUND_GAP;
                                    seq_next.ms    = (round_gap_reg != '0) ?
                                                     round_gap_reg : MS_W'(1);
                                end
                            end
                            PH_ROUND_GAP:
                            begin
                                if (!held_forever_reg &&
                                    (rounds_done_reg + ROUND_W'(1)) >= total)
                                begin
                                    seq_next         = '0;
                                    rounds_done_next = '0;
                                end
                                else
                                begin
                                    if (!held_forever_reg)
                                    begin
                                        rounds_done_next = rounds_done_reg + ROUND_W'(1);
                                    end
                                    seq_next = begin_round(held_src_reg, held_code_reg,
                                        held_half_reg, source_gap_reg, round_gap_reg);
                                end
                            end
                            default:
                            begin
                                seq_next         = '0;
                                rounds_done_next = '0;
                            end
                        endcase
                    end
                end
            end
            ACT_REQUEST:
            begin
                // A request starts a sequence only from idle.
                if (seq_reg.phase == PH_IDLE)
                begin
                    held_src_next     = in_src;
                    held_code_next    = in_code;
                    held_half_next    = (in_half != '0) ? in_half : HALF_W'(1);
                    held_forever_next = in_forever;
                    rounds_done_next  = '0;
                    seq_next = begin_round(in_src, in_code, held_half_next,
                        source_gap_reg, round_gap_reg);
                    taken = 1'b1;
                end
            end
            ACT_OFF:
            begin
                seq_next         = '0;
                rounds_done_next = '0;
            end
            default:
            begin
                seq_next = seq_reg;
            end
        endcase

        out_data_next = {taken, (seq_next.phase != PH_IDLE),
                         (seq_next.phase == PH_SRC_ON || seq_next.phase == PH_CODE_ON)};
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_gap_reg  <= SOURCE_GAP_RST;
            round_gap_reg   <= ROUND_GAP_RST;
            round_total_reg <= ROUND_TOTAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_SOURCE_GAP:  source_gap_reg  <= cfg_data;
                REG_ROUND_GAP:   round_gap_reg   <= cfg_data;
                REG_ROUND_TOTAL: round_total_reg <= cfg_data[ROUND_W-1:0];
                default:         round_total_reg <= round_total_reg;
            endcase
        end
    end

    // Sequencer state, updated on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg          <= '0;
            rounds_done_reg  <= '0;
            held_src_reg     <= '0;
            held_code_reg    <= '0;
            held_half_reg    <= '0;
            held_forever_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            seq_reg          <= seq_next;
            rounds_done_reg  <= rounds_done_next;
            held_src_reg     <= held_src_next;
            held_code_reg    <= held_code_next;
            held_half_reg    <= held_half_next;
            held_forever_reg <= held_forever_next;
        end
    end

    // Result word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
